/* rtl/tsga_pkg.sv */
// Shared widths, register indexes, reset values and types for the two-source gravity core.
package tsga_pkg;

  // Channel and field widths.
  localparam int POS_W  = 32;
  localparam int NSRC   = 2;
  localparam int NAX    = 3;
  localparam int NLANE  = NSRC * NAX;
  localparam int IN_W   = POS_W * NAX * (NSRC + 1);
  localparam int OUT_W  = 40;
  localparam int OUT_DW = OUT_W * NAX;
  localparam int USER_W = 2;

  // Configuration port.
  localparam int GM_W    = 50;
  localparam int GM_LO_W = 25;
  localparam int CFG_IW  = 2;
  localparam logic [CFG_IW-1:0] REG_GM_PRIMARY   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GM_SECONDARY = 2'd1;
  localparam logic [GM_W-1:0] GM_PRIMARY_RST   = 50'd398618300000000;
  localparam logic [GM_W-1:0] GM_SECONDARY_RST = 50'd4903120000000;

  // Datapath widths.
  localparam int ACC_FRAC = 24;
  localparam int MAG_W    = POS_W + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int GP_W     = GM_LO_W + MAG_W;
  localparam int G_W      = 82;
  localparam int GLW      = 28;
  localparam int GL       = 3;
  localparam int G2_W     = 2 * G_W;
  localparam int SLW      = 33;
  localparam int SP_W     = 2 * SLW;
  localparam int S_W      = 66;
  localparam int S2_W     = 132;
  localparam int S3_W     = 198;
  localparam int RW       = G2_W + 2 * ACC_FRAC;
  localparam int QB       = OUT_W;
  localparam int CW       = S3_W + 2 * (QB - 1) + 2;
  localparam int TERM_W   = OUT_W + 1;
  localparam int SUM_W    = OUT_W + 2;

  // Term cap and output clipping bounds.
  localparam logic [QB-1:0] Q_CAP = {1'b1, {(QB-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // Per-lane side information: sign of the offset and coincidence of its source.
  typedef struct packed {
    logic neg;
    logic coinc;
  } tsga_tag_t;

  // One finished result.
  typedef struct packed {
    logic              sat;
    logic              coinc;
    logic [OUT_W-1:0]  az;
    logic [OUT_W-1:0]  ay;
    logic [OUT_W-1:0]  ax;
  } tsga_res_t;

endpackage

/* rtl/two_source_gravity_accel_core.sv */
// Top level: configuration registers, pipeline, output queue and checks.
//
// Channel  | Direction | Transfer when           | Content
// in_      | in        | in_tvalid & in_tready   | tdata: body, primary, secondary xyz
// out_     | out       | out_tvalid & out_tready | tdata: accel xyz, tuser: flags
// cfg_     | in        | cfg_wr_en               | GM of primary (0) or secondary (1)
//
// One item enters per cycle while the output queue has room. Each input passes through
// 7 front stages (offsets, multiply and adder levels), the 40-stage quotient search, one
// bit per stage, and 2 summing stages. A two-entry output queue takes results while the
// sink stalls; the pipeline only holds when that queue is full. Synchronous reset clears
// all valid bits and loads the reset GM values.
module two_source_gravity_accel_core
  import tsga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // body_x, body_y, body_z, primary_x, primary_y, primary_z, secondary_x, secondary_y,
  // secondary_z (32 bits each, from the lowest bit up)
  input  logic [IN_W-1:0]     in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // accel_x, accel_y, accel_z (40 bits each, from the lowest bit up)
  output logic [OUT_DW-1:0]   out_tdata,
  // coincident_flag, saturated_flag (from the lowest bit up)
  output logic [USER_W-1:0]   out_tuser,
  input  logic                cfg_wr_en,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [GM_W-1:0]     cfg_data
);

  logic [GM_W-1:0]  gm_primary_r;
  logic [GM_W-1:0]  gm_secondary_r;

  logic             pipe_en;
  logic             prep_valid;
  logic [RW-1:0]    n2 [NLANE];
  logic [S3_W-1:0]  s3 [NSRC];
  tsga_tag_t        tag_p [NLANE];
  logic [QB-1:0]    rv_r;
  logic [QB-1:0]    q [NLANE];
  tsga_tag_t        tag_q [NLANE];
  logic             sum_valid;
  tsga_res_t        sum_res;

  tsga_res_t        fifo_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;
  tsga_res_t        head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_primary_r   <= GM_PRIMARY_RST;
      gm_secondary_r <= GM_SECONDARY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GM_PRIMARY:   gm_primary_r   <= cfg_data;
        REG_GM_SECONDARY: gm_secondary_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances while the output queue has room.
  assign pipe_en   = (cnt_r != 2'd2);
  assign in_tready = pipe_en;

  tsga_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .in_valid     (in_tvalid),
    .in_data      (in_tdata),
    .gm_primary   (gm_primary_r),
    .gm_secondary (gm_secondary_r),
    .out_valid    (prep_valid),
    .n2_out       (n2),
    .s3_out       (s3),
    .tag_out      (tag_p)
  );

  // Valid bits for the quotient search stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (pipe_en) begin
      rv_r <= {rv_r[QB-2:0], prep_valid};
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    tsga_root u_root (
      .clk     (clk),
      .en      (pipe_en),
      .n2_in   (n2[l]),
      .s3_in   (s3[l / NAX]),
      .tag_in  (tag_p[l]),
      .q_out   (q[l]),
      .tag_out (tag_q[l])
    );
  end

  tsga_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (rv_r[QB-1]),
    .q_in      (q),
    .tag_in    (tag_q),
    .out_valid (sum_valid),
    .res_out   (sum_res)
  );

  // Two-entry output queue.
  assign push = pipe_en & sum_valid;
  assign pop  = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= sum_res;
    end
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {head.az, head.ay, head.ax};
  assign out_tuser  = {head.sat, head.coinc};

`ifndef SYNTHESIS
  // The queue never holds more than two results.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output queue count out of range");

  // A result is never written into a full queue without one leaving.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2))
    else $error("output queue overrun");

  // While the pipeline holds, its valid bits do not move.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(rv_r) && $stable(sum_valid))
    else $error("pipeline moved during a hold");
`endif

endmodule

/* rtl/tsga_prep.sv */
// Front pipeline: offsets, squared distance, numerator squares and cubed squared distance.
module tsga_prep
  import tsga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_data,
  input  logic [GM_W-1:0]     gm_primary,
  input  logic [GM_W-1:0]     gm_secondary,
  output logic                out_valid,
  output logic [RW-1:0]       n2_out [NLANE],
  output logic [S3_W-1:0]     s3_out [NSRC],
  output tsga_tag_t           tag_out [NLANE]
);

  logic [6:0]          v_r;

  logic [MAG_W-1:0]    mag1_r [NLANE];
  logic [NLANE-1:0]    neg1_r, neg2_r, neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [SQ_W-1:0]     sq2_r  [NLANE];
  logic [GP_W-1:0]     gpl2_r [NLANE];
  logic [GP_W-1:0]     gph2_r [NLANE];
  logic [S_W-1:0]      s3s_r  [NSRC];
  logic [G_W-1:0]      g3_r   [NLANE];
  logic [NSRC-1:0]     co3_r, co4_r, co5_r, co6_r, co7_r;
  logic [SP_W-1:0]     ps4_r  [NSRC][4];
  logic [2*GLW-1:0]    pg4_r  [NLANE][GL*GL];
  logic [S_W-1:0]      s4_r   [NSRC];
  logic [S2_W-1:0]     s25_r  [NSRC];
  logic [G2_W-1:0]     g25_r  [NLANE];
  logic [S_W-1:0]      s5_r   [NSRC];
  logic [SP_W-1:0]     p6_r   [NSRC][8];
  logic [G2_W-1:0]     g26_r  [NLANE];
  logic [S3_W-1:0]     s37_r  [NSRC];
  logic [RW-1:0]       n27_r  [NLANE];

  logic [MAG_W-1:0]    mag_nxt [NLANE];
  logic [NLANE-1:0]    neg_nxt;
  logic [S_W-1:0]      ssum_nxt [NSRC];
  logic [G_W-1:0]      g_nxt    [NLANE];
  logic [S2_W-1:0]     s2_nxt   [NSRC];
  logic [G2_W-1:0]     g2_nxt   [NLANE];
  logic [S3_W-1:0]     s3_nxt   [NSRC];

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // Offset of the body from each source, split into sign and magnitude.
  always_comb begin
    logic signed [MAG_W-1:0] b_ext;
    logic signed [MAG_W-1:0] p_ext;
    logic signed [MAG_W-1:0] d;
    b_ext = '0;
    p_ext = '0;
    d     = '0;
    for (int s = 0; s < NSRC; s++) begin
      for (int k = 0; k < NAX; k++) begin
        b_ext = MAG_W'(signed'(in_data[POS_W*k +: POS_W]));
        p_ext = MAG_W'(signed'(in_data[POS_W*(NAX*(s+1)+k) +: POS_W]));
        d     = b_ext - p_ext;
        neg_nxt[s*NAX+k] = d[MAG_W-1];
        mag_nxt[s*NAX+k] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
    end
  end

  // Sum of squares per source and the gravitational numerator per lane.
  always_comb begin
    for (int s = 0; s < NSRC; s++) begin
      ssum_nxt[s] = sq2_r[s*NAX] + sq2_r[s*NAX+1] + sq2_r[s*NAX+2];
    end
    for (int l = 0; l < NLANE; l++) begin
      g_nxt[l] = G_W'(gpl2_r[l]) + (G_W'(gph2_r[l]) << GM_LO_W);
    end
  end

  // Recombine the partial products of the squares.
  always_comb begin
    for (int s = 0; s < NSRC; s++) begin
      s2_nxt[s] = '0;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          s2_nxt[s] = s2_nxt[s] + (S2_W'(ps4_r[s][i*2+j]) << (SLW*(i+j)));
        end
      end
    end
    for (int l = 0; l < NLANE; l++) begin
      g2_nxt[l] = '0;
      for (int i = 0; i < GL; i++) begin
        for (int j = 0; j < GL; j++) begin
          g2_nxt[l] = g2_nxt[l] + (G2_W'(pg4_r[l][i*GL+j]) << (GLW*(i+j)));
        end
      end
    end
  end

  // Recombine the partial products of the cube.
  always_comb begin
    for (int s = 0; s < NSRC; s++) begin
      s3_nxt[s] = '0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          s3_nxt[s] = s3_nxt[s] + (S3_W'(p6_r[s][i*2+j]) << (SLW*(i+j)));
        end
      end
    end
  end

  // Pipeline registers; each stage holds one multiply level or one adder level.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: offsets.
      mag1_r <= mag_nxt;
      neg1_r <= neg_nxt;
      // Stage 2: squares and the two halves of GM times offset.
      for (int l = 0; l < NLANE; l++) begin
        sq2_r[l]  <= SQ_W'(mag1_r[l]) * SQ_W'(mag1_r[l]);
        gpl2_r[l] <= (l < NAX) ? GP_W'(gm_primary[GM_LO_W-1:0]) * GP_W'(mag1_r[l])
                               : GP_W'(gm_secondary[GM_LO_W-1:0]) * GP_W'(mag1_r[l]);
        gph2_r[l] <= (l < NAX) ? GP_W'(gm_primary[GM_W-1:GM_LO_W]) * GP_W'(mag1_r[l])
                               : GP_W'(gm_secondary[GM_W-1:GM_LO_W]) * GP_W'(mag1_r[l]);
      end
      neg2_r <= neg1_r;
      // Stage 3: squared distance and numerator.
      s3s_r <= ssum_nxt;
      g3_r  <= g_nxt;
      for (int s = 0; s < NSRC; s++) begin
        co3_r[s] <= (ssum_nxt[s] == '0);
      end
      neg3_r <= neg2_r;
      // Stage 4: limb products for the squared distance squared and the numerator squared.
      for (int s = 0; s < NSRC; s++) begin
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 2; j++) begin
            ps4_r[s][i*2+j] <= SP_W'(s3s_r[s][SLW*i +: SLW]) * SP_W'(s3s_r[s][SLW*j +: SLW]);
          end
        end
      end
      for (int l = 0; l < NLANE; l++) begin
        for (int i = 0; i < GL; i++) begin
          for (int j = 0; j < GL; j++) begin
            pg4_r[l][i*GL+j] <= (2*GLW)'(({2'b00, g3_r[l]} >> (GLW*i)) & {GLW{1'b1}})
                              * (2*GLW)'(({2'b00, g3_r[l]} >> (GLW*j)) & {GLW{1'b1}});
          end
        end
      end
      s4_r   <= s3s_r;
      co4_r  <= co3_r;
      neg4_r <= neg3_r;
      // Stage 5: sums of the limb products.
      s25_r  <= s2_nxt;
      g25_r  <= g2_nxt;
      s5_r   <= s4_r;
      co5_r  <= co4_r;
      neg5_r <= neg4_r;
      // Stage 6: limb products for the cube.
      for (int s = 0; s < NSRC; s++) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 2; j++) begin
            p6_r[s][i*2+j] <= SP_W'(s25_r[s][SLW*i +: SLW]) * SP_W'(s5_r[s][SLW*j +: SLW]);
          end
        end
      end
      g26_r  <= g25_r;
      co6_r  <= co5_r;
      neg6_r <= neg5_r;
      // Stage 7: cube sum and the scaled numerator square.
      s37_r <= s3_nxt;
      for (int l = 0; l < NLANE; l++) begin
        n27_r[l] <= RW'(g26_r[l]) << (2*ACC_FRAC);
      end
      co7_r  <= co6_r;
      neg7_r <= neg6_r;
    end
  end

  assign out_valid = v_r[6];
  assign n2_out    = n27_r;
  assign s3_out    = s37_r;

  always_comb begin
    for (int s = 0; s < NSRC; s++) begin
      for (int k = 0; k < NAX; k++) begin
        tag_out[s*NAX+k].neg   = neg7_r[s*NAX+k];
        tag_out[s*NAX+k].coinc = co7_r[s];
      end
    end
  end

endmodule

/* rtl/tsga_root.sv */
// One lane of the bit-serial quotient search: one quotient bit per pipeline stage.
module tsga_root
  import tsga_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [RW-1:0]    n2_in,
  input  logic [S3_W-1:0]  s3_in,
  input  tsga_tag_t        tag_in,
  output logic [QB-1:0]    q_out,
  output tsga_tag_t        tag_out
);

  // Remainder n^2 - c^2*S^3 and running product c*S^3 between stages.
  logic [RW-1:0]    r_r   [QB-1];
  logic [RW-1:0]    t_r   [QB-1];
  logic [S3_W-1:0]  s3_r  [QB-1];
  logic [QB-1:0]    q_r   [QB];
  tsga_tag_t        tag_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int B = QB - 1 - i;

    logic [RW-1:0]    r_cur;
    logic [RW-1:0]    t_cur;
    logic [S3_W-1:0]  s3_cur;
    logic [QB-1:0]    q_cur;
    tsga_tag_t        tag_cur;
    logic [CW-1:0]    cand;
    logic             take;
    logic [QB-1:0]    q_nxt;

    if (i == 0) begin : g_first
      assign r_cur   = n2_in;
      assign t_cur   = '0;
      assign s3_cur  = s3_in;
      assign q_cur   = '0;
      assign tag_cur = tag_in;
    end else begin : g_next
      assign r_cur   = r_r[i-1];
      assign t_cur   = t_r[i-1];
      assign s3_cur  = s3_r[i-1];
      assign q_cur   = q_r[i-1];
      assign tag_cur = tag_r[i-1];
    end

    // Setting bit B raises c^2*S^3 by S^3*2^(2B) + c*S^3*2^(B+1).
    assign cand  = (CW'(s3_cur) << (2*B)) + (CW'(t_cur) << (B+1));
    assign take  = (cand <= CW'(r_cur));
    assign q_nxt = q_cur | (QB'(take) << B);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= q_nxt;
        tag_r[i] <= tag_cur;
      end
    end

    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[i]  <= take ? r_cur - cand[RW-1:0] : r_cur;
          t_r[i]  <= take ? t_cur + (RW'(s3_cur) << B) : t_cur;
          s3_r[i] <= s3_cur;
        end
      end
    end
  end

  assign q_out   = q_r[QB-1];
  assign tag_out = tag_r[QB-1];

endmodule

/* rtl/tsga_sum.sv */
// Back pipeline: term cap and sign, sum of the two sources, output clipping and flags.
module tsga_sum
  import tsga_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [QB-1:0] q_in [NLANE],
  input  tsga_tag_t   tag_in [NLANE],
  output logic        out_valid,
  output tsga_res_t   res_out
);

  logic [1:0]               v_r;
  logic signed [TERM_W-1:0] term1_r [NLANE];
  logic                     sat1_r;
  logic                     co1_r;
  tsga_res_t                res2_r;

  logic signed [TERM_W-1:0] term_nxt [NLANE];
  logic                     sat_nxt;
  logic                     co_nxt;
  tsga_res_t                res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  // Cap each term and point it against the offset; a coincident source adds nothing.
  always_comb begin
    logic [QB-1:0] qc;
    qc      = '0;
    sat_nxt = 1'b0;
    co_nxt  = 1'b0;
    for (int l = 0; l < NLANE; l++) begin
      qc = (q_in[l] > Q_CAP) ? Q_CAP : q_in[l];
      if (tag_in[l].coinc) begin
        term_nxt[l] = '0;
      end else if (tag_in[l].neg) begin
        term_nxt[l] = signed'({1'b0, qc});
      end else begin
        term_nxt[l] = -signed'({1'b0, qc});
      end
      sat_nxt = sat_nxt | ((q_in[l] > Q_CAP) & ~tag_in[l].coinc);
      co_nxt  = co_nxt | tag_in[l].coinc;
    end
  end

  // Add the two sources per axis and clip to the output range.
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic [OUT_W-1:0]        a [NAX];
    logic                    sat;
    s   = '0;
    sat = sat1_r;
    for (int k = 0; k < NAX; k++) begin
      s = SUM_W'(term1_r[k]) + SUM_W'(term1_r[NAX+k]);
      if (s > SUM_HI) begin
        a[k] = SUM_HI[OUT_W-1:0];
        sat  = 1'b1;
      end else if (s < SUM_LO) begin
        a[k] = SUM_LO[OUT_W-1:0];
        sat  = 1'b1;
      end else begin
        a[k] = s[OUT_W-1:0];
      end
    end
    res_nxt.ax    = a[0];
    res_nxt.ay    = a[1];
    res_nxt.az    = a[2];
    res_nxt.coinc = co1_r;
    res_nxt.sat   = sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term1_r <= term_nxt;
      sat1_r  <= sat_nxt;
      co1_r   <= co_nxt;
      res2_r  <= res_nxt;
    end
  end

  assign out_valid = v_r[1];
  assign res_out   = res2_r;

endmodule

/* bench/two_source_gravity_accel_core_tb.sv */
// Self-checking testbench for the two-source gravity acceleration core.
module two_source_gravity_accel_core_tb;
  import tsga_pkg::*;

  typedef logic [335:0] wide_t;

  // Keeps the GM registers, computes expected accelerations and compares results.
  class accel_scoreboard;
    logic [GM_W-1:0] gm_pri;
    logic [GM_W-1:0] gm_sec;
    tsga_res_t       pending[$];
    int              errors;
    int              checked;
    int              coinc_seen;
    int              sat_seen;

    function new();
      gm_pri = GM_PRIMARY_RST;
      gm_sec = GM_SECONDARY_RST;
      errors = 0;
      checked = 0;
      coinc_seen = 0;
      sat_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [GM_W-1:0] val);
      if (idx == REG_GM_PRIMARY) gm_pri = val;
      else if (idx == REG_GM_SECONDARY) gm_sec = val;
    endfunction

    // Adds the attraction of one source into the three running sums.
    function void add_source(logic [GM_W-1:0] gm, longint bod[3], longint src[3],
                             ref longint acc[3], ref bit coinc, ref bit sat);
      longint d;
      logic [63:0] mag[3];
      bit neg[3];
      wide_t s, s3, n, n2, c2;
      logic [QB-1:0] q, c;
      s = '0;
      for (int k = 0; k < 3; k++) begin
        d = bod[k] - src[k];
        neg[k] = d < 0;
        mag[k] = neg[k] ? -d : d;
        s = s + wide_t'(mag[k]) * wide_t'(mag[k]);
      end
      if (s == 0) begin
        coinc = 1;
        return;
      end
      s3 = s * s * s;
      for (int k = 0; k < 3; k++) begin
        n = (wide_t'(gm) * wide_t'(mag[k])) << ACC_FRAC;
        n2 = n * n;
        q = '0;
        // Largest q with q^2 * |d|^6 <= n^2, one bit at a time.
        for (int b = QB - 1; b >= 0; b--) begin
          c = q | (40'd1 << b);
          c2 = wide_t'(c) * wide_t'(c) * s3;
          if (c2 <= n2) q = c;
        end
        if (q > Q_CAP) begin
          q = Q_CAP;
          sat = 1;
        end
        if (neg[k]) acc[k] += longint'(q);
        else acc[k] -= longint'(q);
      end
    endfunction

    // Notes an accepted input transfer and queues its expected result.
    function void note_input(logic [IN_W-1:0] data);
      longint bod[3], pri[3], sec[3], acc[3];
      bit coinc, sat;
      longint hi, lo, v;
      tsga_res_t r;
      hi = (longint'(1) << 39) - 1;
      lo = -hi - 1;
      coinc = 0;
      sat = 0;
      for (int k = 0; k < 3; k++) begin
        bod[k] = longint'($signed(data[POS_W*k +: POS_W]));
        pri[k] = longint'($signed(data[POS_W*(3+k) +: POS_W]));
        sec[k] = longint'($signed(data[POS_W*(6+k) +: POS_W]));
        acc[k] = 0;
      end
      add_source(gm_pri, bod, pri, acc, coinc, sat);
      add_source(gm_sec, bod, sec, acc, coinc, sat);
      for (int k = 0; k < 3; k++) begin
        v = acc[k];
        if (v > hi) begin
          v = hi;
          sat = 1;
        end
        if (v < lo) begin
          v = lo;
          sat = 1;
        end
        acc[k] = v;
      end
      r.ax = acc[0][OUT_W-1:0];
      r.ay = acc[1][OUT_W-1:0];
      r.az = acc[2][OUT_W-1:0];
      r.coinc = coinc;
      r.sat = sat;
      pending.push_back(r);
    endfunction

    // Compares an accepted output transfer with the oldest expectation.
    function void check_result(logic [OUT_DW-1:0] data, logic [USER_W-1:0] user);
      tsga_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: tdata %h tuser %b", $time, data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.coinc) coinc_seen++;
      if (e.sat) sat_seen++;
      if (data[OUT_W-1:0] !== e.ax) begin
        $display("%0t: accel_x expected %h actual %h", $time, e.ax, data[OUT_W-1:0]);
        errors++;
      end
      if (data[OUT_W +: OUT_W] !== e.ay) begin
        $display("%0t: accel_y expected %h actual %h", $time, e.ay, data[OUT_W +: OUT_W]);
        errors++;
      end
      if (data[2*OUT_W +: OUT_W] !== e.az) begin
        $display("%0t: accel_z expected %h actual %h", $time, e.az, data[2*OUT_W +: OUT_W]);
        errors++;
      end
      if (user[0] !== e.coinc) begin
        $display("%0t: coincident_flag expected %b actual %b", $time, e.coinc, user[0]);
        errors++;
      end
      if (user[1] !== e.sat) begin
        $display("%0t: saturated_flag expected %b actual %b", $time, e.sat, user[1]);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // body_x..z, primary_x..z, secondary_x..z (32 bits each, from the lowest bit up)
  logic [IN_W-1:0]     in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // accel_x, accel_y, accel_z (40 bits each, from the lowest bit up)
  logic [OUT_DW-1:0]   out_tdata;
  // coincident_flag, saturated_flag (from the lowest bit up)
  logic [USER_W-1:0]   out_tuser;
  logic                cfg_wr_en;
  logic [CFG_IW-1:0]   cfg_index;
  logic [GM_W-1:0]     cfg_data;

  accel_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int sent;

  two_source_gravity_accel_core i_dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: random back pressure at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Sends one item, with random idle cycles ahead of it.
  task automatic send_item(logic [IN_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(data);
    sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Writes one register; the block must be idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [GM_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Waits until every queued expectation has been met, then lets the pipeline drain.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack9(logic [POS_W-1:0] p[9]);
    logic [IN_W-1:0] r;
    for (int i = 0; i < 9; i++) r[POS_W*i +: POS_W] = p[i];
    return r;
  endfunction

  // Random item: mostly a body near a source, some coincident, some fully random.
  function automatic logic [IN_W-1:0] rand_item();
    logic [POS_W-1:0] p[9];
    int mode, sh;
    for (int i = 0; i < 9; i++) p[i] = $urandom;
    mode = $urandom_range(99);
    sh = $urandom_range(31);
    if (mode < 45) begin
      for (int k = 0; k < 3; k++) p[k] = p[3+k] + (($urandom >> sh) ^ {32{1'($urandom_range(1))}});
    end else if (mode < 70) begin
      for (int k = 0; k < 3; k++) p[k] = p[6+k] + (($urandom >> sh) ^ {32{1'($urandom_range(1))}});
    end else if (mode < 78) begin
      for (int k = 0; k < 3; k++) p[k] = p[3+k];
    end else if (mode < 84) begin
      for (int k = 0; k < 3; k++) p[k] = p[6+k];
    end else if (mode < 87) begin
      for (int k = 0; k < 3; k++) begin
        p[k] = p[3+k];
        p[6+k] = p[3+k];
      end
    end
    return pack9(p);
  endfunction

  // Edge cases: coincidence, widest offsets, tiny offsets and one-axis offsets.
  task automatic send_directed();
    logic [POS_W-1:0] p[9];
    logic [POS_W-1:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    for (int i = 0; i < 9; i++) p[i] = '0;
    send_item(pack9(p));
    for (int i = 0; i < 9; i++) p[i] = mn;
    send_item(pack9(p));
    for (int i = 0; i < 9; i++) p[i] = (i < 3) ? mn : mx;
    send_item(pack9(p));
    for (int i = 0; i < 9; i++) p[i] = (i < 3) ? mx : mn;
    send_item(pack9(p));
    for (int i = 0; i < 9; i++) p[i] = (i < 6) ? mx : 32'd1000;
    send_item(pack9(p));
    for (int i = 0; i < 9; i++) p[i] = (i >= 3 && i < 6) ? 32'd5 : mn;
    send_item(pack9(p));
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < 9; i++) p[i] = '0;
      p[ax] = 32'd1;
      p[6+ax] = 32'd6_371_000;
      send_item(pack9(p));
      p[ax] = 32'hffff_ffff;
      p[6+ax] = 32'hffa0_0000;
      send_item(pack9(p));
      p[ax] = 32'd6_371_000;
      p[6+ax] = 32'd384_400_000;
      send_item(pack9(p));
    end
    for (int i = 0; i < 9; i++) p[i] = '0;
    p[0] = 32'd3;
    p[1] = 32'hffff_fffc;
    p[2] = 32'd12;
    send_item(pack9(p));
    p[6] = mx;
    p[7] = mn;
    p[8] = mx;
    send_item(pack9(p));
  endtask

  // Timeout guard.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence.
  initial begin
    sb = new();
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset GM values, no idling.
    send_directed();
    repeat (300) send_item(rand_item());
    drain();

    // Both registers at full scale, sender mostly idle.
    write_reg(REG_GM_PRIMARY, '1);
    write_reg(REG_GM_SECONDARY, '1);
    write_reg(2'd2, 50'd17);
    write_reg(2'd3, '0);
    send_idle_pct = 80;
    send_directed();
    repeat (280) send_item(rand_item());
    drain();

    // Zero primary and a random secondary, receiver mostly stalled.
    write_reg(REG_GM_PRIMARY, '0);
    write_reg(REG_GM_SECONDARY, GM_W'({$urandom, $urandom}));
    send_idle_pct = 0;
    recv_stall_pct = 80;
    repeat (320) send_item(rand_item());
    drain();

    // Earth and moon values, both sides idling.
    write_reg(REG_GM_PRIMARY, 50'd398618300000000);
    write_reg(REG_GM_SECONDARY, 50'd1);
    write_reg(REG_GM_SECONDARY, 50'd4903120000000);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    repeat (320) send_item(rand_item());
    drain();

    $display("Sent %0d items over four GM settings and idling mixes; checked %0d results.",
             sent, sb.checked);
    $display("Coincident results: %0d, saturated results: %0d.", sb.coinc_seen, sb.sat_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
